FILE: hdl/rtcsp_pkg.sv
// types, constants and helper functions for the radiotap channel and signal parser
`timescale 1ns / 1ps
`default_nettype none

package rtcsp_pkg;

    localparam int POS_W = 7;
    localparam logic [POS_W-1:0] POS_MAX = 7'd127;
    localparam logic [POS_W-1:0] PRESENT_START = 7'd4;

    localparam logic [3:0] MAX_PRESENT_WORDS = 4'd8;

    localparam logic [15:0] FREQ_CH1 = 16'd2412;
    localparam logic [15:0] FREQ_CH14 = 16'd2484;
    localparam int FREQ_STEP = 5;
    localparam int NUM_STEP_CHANNELS = 13;
    localparam logic [3:0] CH_NONE = 4'd0;
    localparam logic [3:0] CH14 = 4'd14;

    localparam int FOUND_CH = 0;
    localparam int FOUND_SIG = 1;

    localparam int BIT_TSFT = 0;
    localparam int BIT_FLAGS = 1;
    localparam int BIT_RATE = 2;
    localparam int BIT_CHANNEL = 3;
    localparam int BIT_FHSS = 4;
    localparam int BIT_SIGNAL = 5;
    localparam int BIT_EXT = 31;

    typedef struct packed {
        logic [POS_W-1:0] ch_off;
        logic [POS_W-1:0] sig_off;
    } offsets_t;

    typedef struct packed {
        logic [POS_W-1:0] pos;
        logic [31:0]      first_bits;
        logic [31:0]      cur_word;
        logic [3:0]       total;
        logic             chain_done;
        logic             ovf;
        offsets_t         offs;
        logic [15:0]      freq;
        logic [7:0]       sig;
        logic [1:0]       found;
    } parse_state_t;

    // field offsets from the first present word and the present word count
    function automatic offsets_t plan_offsets(input logic [5:0] p, input logic [3:0] total);
        logic [7:0] off;
        offsets_t   r;
        r = '0;
        off = 8'd4 + {2'b00, total, 2'b00};
        if (p[BIT_TSFT]) begin
            off = ((off + 8'd7) & 8'hF8) + 8'd8;
        end
        if (p[BIT_FLAGS]) begin
            off = off + 8'd1;
        end
        if (p[BIT_RATE]) begin
            off = off + 8'd1;
        end
        if (p[BIT_CHANNEL]) begin
            off = (off + 8'd1) & 8'hFE;
            r.ch_off = off[POS_W-1:0];
            off = off + 8'd4;
        end
        if (p[BIT_FHSS]) begin
            off = ((off + 8'd1) & 8'hFE) + 8'd2;
        end
        r.sig_off = off[POS_W-1:0];
        return r;
    endfunction

    // 2.4 ghz frequency to channel number
    function automatic logic [3:0] channel_of(input logic [15:0] f);
        logic [3:0] ch;
        ch = CH_NONE;
        for (int i = 0; i < NUM_STEP_CHANNELS; i++) begin
            if (f == FREQ_CH1 + 16'(FREQ_STEP * i)) begin
                ch = 4'(i + 1);
            end
        end
        if (f == FREQ_CH14) begin
            ch = CH14;
        end
        return ch;
    endfunction

endpackage

`default_nettype wire

FILE: hdl/radiotap_channel_signal_parser.sv
// radiotap header parser that extracts the channel number and antenna signal
//
// input channel: one header byte per request on s_data_byte; s_first_byte
// marks byte 0 of a new header and restarts the parse, s_last_byte asks for
// a result once that byte has been taken. bytes seen before any first mark
// after reset are parsed as a header starting at byte 0.
// result channel: m_channel, m_channel_found, m_signal_dbm, m_signal_found
// and m_present_overflow, one request for every byte marked last.
// latency: the result is valid in the cycle after its last byte is taken.
// throughput: one byte per cycle while s_ready is high; each byte passes one stage
// of logic from the parse state registers into the result register.
// stall: the result register holds its request while m_ready is low; input
// bytes are still taken unless a result is held and m_ready is low.
// reset: aresetn clears the parse state and drops m_valid.
`timescale 1ns / 1ps
`default_nettype none

module radiotap_channel_signal_parser
    import rtcsp_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,

    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire logic [7:0]        s_data_byte,
    input  wire logic              s_first_byte,
    input  wire logic              s_last_byte,

    output logic                   m_valid,
    input  wire logic              m_ready,
    output logic [3:0]             m_channel,
    output logic                   m_channel_found,
    output logic signed [7:0]      m_signal_dbm,
    output logic                   m_signal_found,
    output logic                   m_present_overflow
);

    parse_state_t state_reg;
    parse_state_t state_next;
    parse_state_t base;

    logic              accept;
    logic [1:0]        idx;
    logic [7:0]        pos_ext;
    logic [7:0]        ch_hi_pos;

    logic              m_valid_reg;
    logic [3:0]        channel_reg;
    logic [3:0]        channel_next;
    logic              channel_found_reg;
    logic signed [7:0] signal_dbm_reg;
    logic signed [7:0] signal_dbm_next;
    logic              signal_found_reg;
    logic              overflow_reg;

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    assign idx       = base.pos[1:0];
    assign pos_ext   = {1'b0, base.pos};
    assign ch_hi_pos = {1'b0, base.offs.ch_off} + 8'd1;

    always_comb begin
        base = s_first_byte ? '0 : state_reg;
        state_next = base;
        if (!base.chain_done) begin
            if (base.pos >= PRESENT_START) begin
                if (idx == 2'd0) begin
                    state_next.cur_word = {24'd0, s_data_byte};
                end else begin
                    state_next.cur_word = base.cur_word
                                        | ({24'd0, s_data_byte} << {idx, 3'b000});
                end
                if (idx == 2'd3) begin
                    if (base.total == 4'd0) begin
                        state_next.first_bits = state_next.cur_word;
                    end
                    state_next.total = base.total + 4'd1;
                    if (!state_next.cur_word[BIT_EXT]) begin
                        state_next.chain_done = 1'b1;
                        state_next.offs = plan_offsets(state_next.first_bits[5:0],
                                                       state_next.total);
                    end else if (state_next.total >= MAX_PRESENT_WORDS) begin
                        state_next.chain_done = 1'b1;
                        state_next.ovf = 1'b1;
                    end
                end
            end
        end else if (!base.ovf) begin
            if (base.first_bits[BIT_CHANNEL] && base.pos == base.offs.ch_off) begin
                state_next.freq[7:0] = s_data_byte;
            end
            if (base.first_bits[BIT_CHANNEL] && pos_ext == ch_hi_pos) begin
                state_next.freq[15:8] = s_data_byte;
                state_next.found[FOUND_CH] = 1'b1;
            end
            if (base.first_bits[BIT_SIGNAL] && base.pos == base.offs.sig_off) begin
                state_next.sig = s_data_byte;
                state_next.found[FOUND_SIG] = 1'b1;
            end
        end
        if (base.pos < POS_MAX) begin
            state_next.pos = base.pos + 7'd1;
        end
    end

    assign channel_next    = state_next.found[FOUND_CH] ? channel_of(state_next.freq) : CH_NONE;
    assign signal_dbm_next = state_next.found[FOUND_SIG] ? $signed(state_next.sig) : 8'sd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                state_reg <= state_next;
            end
            if (accept && s_last_byte) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge aclk) begin
        if (accept && s_last_byte) begin
            channel_reg       <= channel_next;
            channel_found_reg <= state_next.found[FOUND_CH];
            signal_dbm_reg    <= signal_dbm_next;
            signal_found_reg  <= state_next.found[FOUND_SIG];
            overflow_reg      <= state_next.ovf;
        end
    end

    assign m_valid            = m_valid_reg;
    assign m_channel          = channel_reg;
    assign m_channel_found    = channel_found_reg;
    assign m_signal_dbm       = signal_dbm_reg;
    assign m_signal_found     = signal_found_reg;
    assign m_present_overflow = overflow_reg;

    a_ovf_no_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && overflow_reg |-> !channel_found_reg && !signal_found_reg)
        else $error("field reported on an overflowed present chain");

    a_channel_needs_found: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && channel_reg != CH_NONE |-> channel_found_reg)
        else $error("channel number without a captured frequency");

    a_channel_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> channel_reg <= CH14)
        else $error("channel number out of range");

    a_signal_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && !signal_found_reg |-> signal_dbm_reg == 8'sd0)
        else $error("signal value given without a captured signal byte");

    a_pos_saturates: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg.pos == POS_MAX && !(s_valid && s_ready && s_first_byte)
        |=> state_reg.pos == POS_MAX)
        else $error("byte position wrapped");

endmodule

`default_nettype wire

FILE: bench/radiotap_channel_signal_parser_test.sv
// self-checking testbench for the radiotap channel and signal parser
`timescale 1ns / 1ps

import rtcsp_pkg::*;

typedef bit [7:0] byte_q_t[$];

typedef struct packed {
    logic [3:0]        channel;
    logic              channel_found;
    logic signed [7:0] signal_dbm;
    logic              signal_found;
    logic              present_overflow;
} radio_report_t;

// field offsets from the first present word and the present word count
function automatic void field_offsets(input bit [5:0] p, input int words,
                                      output int chan_at, output int sig_at);
    int at;
    at = 4 + 4 * words;
    chan_at = 0;
    if (p[BIT_TSFT]) at = ((at + 7) / 8) * 8 + 8;
    if (p[BIT_FLAGS]) at += 1;
    if (p[BIT_RATE]) at += 1;
    if (p[BIT_CHANNEL]) begin
        at += at % 2;
        chan_at = at;
        at += 4;
    end
    if (p[BIT_FHSS]) at += at % 2 + 2;
    sig_at = at;
endfunction

class channel_signal_tracker;
    bit [POS_W-1:0] pos;
    bit [31:0]      first_bits;
    bit [31:0]      cur_word;
    bit [3:0]       words_seen;
    bit             chain_done;
    bit             chain_overflow;
    bit [POS_W-1:0] chan_off;
    bit [POS_W-1:0] sig_off;
    bit [15:0]      freq;
    bit [7:0]       sig;
    bit             chan_seen;
    bit             sig_seen;
    radio_report_t  pending_reports[$];
    int             errors;

    function new();
        restart();
        errors = 0;
    endfunction

    function void restart();
        pos = '0;
        first_bits = '0;
        cur_word = '0;
        words_seen = '0;
        chain_done = 1'b0;
        chain_overflow = 1'b0;
        chan_off = '0;
        sig_off = '0;
        freq = '0;
        sig = '0;
        chan_seen = 1'b0;
        sig_seen = 1'b0;
    endfunction

    static function bit [3:0] channel_number(input bit [15:0] f);
        int d;
        d = int'(f) - int'(FREQ_CH1);
        if (d >= 0 && d <= FREQ_STEP * (NUM_STEP_CHANNELS - 1) && d % FREQ_STEP == 0)
            return 4'(d / FREQ_STEP + 1);
        if (f == FREQ_CH14) return CH14;
        return CH_NONE;
    endfunction

    function void take_byte(input bit [7:0] b, input bit first, input bit last);
        int            chan_at;
        int            sig_at;
        int            lane;
        radio_report_t r;
        if (first) restart();
        if (!chain_done) begin
            if (pos >= PRESENT_START) begin
                lane = (int'(pos) - int'(PRESENT_START)) % 4;
                if (lane == 0) cur_word = {24'd0, b};
                else cur_word[8*lane +: 8] = b;
                if (lane == 3) begin
                    if (words_seen == 0) first_bits = cur_word;
                    words_seen++;
                    if (!cur_word[BIT_EXT]) begin
                        chain_done = 1'b1;
                        field_offsets(first_bits[5:0], words_seen, chan_at, sig_at);
                        chan_off = chan_at[POS_W-1:0];
                        sig_off = sig_at[POS_W-1:0];
                    end else if (words_seen >= MAX_PRESENT_WORDS) begin
                        chain_done = 1'b1;
                        chain_overflow = 1'b1;
                    end
                end
            end
        end else if (!chain_overflow) begin
            if (first_bits[BIT_CHANNEL] && pos == chan_off) freq[7:0] = b;
            if (first_bits[BIT_CHANNEL] && int'(pos) == int'(chan_off) + 1) begin
                freq[15:8] = b;
                chan_seen = 1'b1;
            end
            if (first_bits[BIT_SIGNAL] && pos == sig_off) begin
                sig = b;
                sig_seen = 1'b1;
            end
        end
        if (pos != POS_MAX) pos++;
        if (last) begin
            r.channel = chan_seen ? channel_number(freq) : CH_NONE;
            r.channel_found = chan_seen;
            r.signal_dbm = sig_seen ? sig : 8'd0;
            r.signal_found = sig_seen;
            r.present_overflow = chain_overflow;
            pending_reports.push_back(r);
        end
    endfunction

    function void check_field(input string name, input logic signed [31:0] want,
                              input logic signed [31:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, want, got);
            errors++;
        end
    endfunction

    function void match_result(input radio_report_t got);
        radio_report_t want;
        if (pending_reports.size() == 0) begin
            $display("%0t: unexpected result: expected none, got channel %0d signal %0d",
                     $time, got.channel, got.signal_dbm);
            errors++;
            return;
        end
        want = pending_reports.pop_front();
        check_field("channel", want.channel, got.channel);
        check_field("channel_found", want.channel_found, got.channel_found);
        check_field("signal_dbm", want.signal_dbm, got.signal_dbm);
        check_field("signal_found", want.signal_found, got.signal_found);
        check_field("present_overflow", want.present_overflow, got.present_overflow);
    endfunction

    function int pending();
        return pending_reports.size();
    endfunction
endclass

module radiotap_channel_signal_parser_test;

    localparam int STALL_LIMIT = 3000;
    localparam int HOLD_OFF_CYCLES = 300;

    logic              aclk;
    logic              aresetn = 1'b0;
    logic              s_valid = 1'b0;
    logic              s_ready;
    logic [7:0]        s_data_byte = 8'd0;
    logic              s_first_byte = 1'b0;
    logic              s_last_byte = 1'b0;
    logic              m_valid;
    logic              m_ready = 1'b0;
    logic [3:0]        m_channel;
    logic              m_channel_found;
    logic signed [7:0] m_signal_dbm;
    logic              m_signal_found;
    logic              m_present_overflow;

    channel_signal_tracker tracker;
    int                    send_idle_pct = 31;
    int                    recv_idle_pct = 88;
    bit                    hold_off_req = 1'b0;
    int                    bytes_taken = 0;
    int                    idle_cycles = 0;

    radiotap_channel_signal_parser dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_data_byte       (s_data_byte),
        .s_first_byte      (s_first_byte),
        .s_last_byte       (s_last_byte),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_channel         (m_channel),
        .m_channel_found   (m_channel_found),
        .m_signal_dbm      (m_signal_dbm),
        .m_signal_found    (m_signal_found),
        .m_present_overflow(m_present_overflow)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready) begin
            tracker.take_byte(s_data_byte, s_first_byte, s_last_byte);
        end
        if (aresetn && m_valid && m_ready) begin
            tracker.match_result({m_channel, m_channel_found, m_signal_dbm,
                                  m_signal_found, m_present_overflow});
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles = 0;
        else idle_cycles++;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin
        forever begin
            @(posedge aclk);
            if (hold_off_req) begin
                m_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge aclk);
                hold_off_req = 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    task automatic offer_byte(input bit [7:0] b, input bit first, input bit last);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data_byte <= b;
        s_first_byte <= first;
        s_last_byte <= last;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        bytes_taken++;
    endtask

    task automatic offer_frame(input byte_q_t hdr, input bit mark_first, input int extra_last_pct);
        foreach (hdr[i]) begin
            offer_byte(hdr[i], mark_first && i == 0,
                       i == hdr.size() - 1 || $urandom_range(99) < extra_last_pct);
        end
    endtask

    function automatic void make_header(output byte_q_t hdr);
        int        kind;
        int        words;
        int        chan_at;
        int        sig_at;
        int        need;
        int        cut;
        bit        overflow_chain;
        bit [31:0] w;
        bit [5:0]  p;
        bit [15:0] f;
        hdr = {};
        p = '0;
        kind = $urandom_range(99);
        overflow_chain = (kind < 10);
        if (overflow_chain) words = int'(MAX_PRESENT_WORDS);
        else if (kind < 20) words = $urandom_range(1, int'(MAX_PRESENT_WORDS));
        else words = $urandom_range(1, 2);
        repeat (4) hdr.push_back(8'($urandom_range(255)));
        for (int i = 0; i < words; i++) begin
            w = $urandom();
            if (i == 0) begin
                w[BIT_CHANNEL] = ($urandom_range(9) < 7);
                w[BIT_SIGNAL] = ($urandom_range(9) < 7);
            end
            w[BIT_EXT] = overflow_chain || (i < words - 1);
            if (i == 0) p = w[5:0];
            for (int j = 0; j < 4; j++) hdr.push_back(w[8*j +: 8]);
        end
        field_offsets(p, words, chan_at, sig_at);
        need = overflow_chain ? hdr.size() + $urandom_range(0, 12) : sig_at + 1;
        need += $urandom_range(0, 3);
        // long header, runs past the saturation point of the byte counter
        if (kind >= 97) need = $urandom_range(128, 136);
        while (hdr.size() < need) hdr.push_back(8'($urandom_range(255)));
        if (!overflow_chain && p[BIT_CHANNEL]) begin
            case ($urandom_range(4))
                0, 1: f = FREQ_CH1 + 16'(FREQ_STEP * $urandom_range(0, NUM_STEP_CHANNELS - 1));
                2: f = FREQ_CH14;
                3: f = FREQ_CH1 - 16'd5 + 16'($urandom_range(0, 80));
                default: f = 16'($urandom());
            endcase
            hdr[chan_at] = f[7:0];
            hdr[chan_at + 1] = f[15:8];
        end
        // short header, cut at a random length that can end before its fields are complete
        if (kind >= 88 && kind < 97) begin
            cut = $urandom_range(1, hdr.size() - 1);
            while (hdr.size() > cut) void'(hdr.pop_back());
        end
    endfunction

    initial begin
        byte_q_t frame;
        tracker = new();
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // parsed from byte 0 without a first mark: channel 1, weakest signal
        frame = {8'h00, 8'hFF, 8'h0D, 8'h00, 8'h28, 8'h00, 8'h00, 8'h00,
                 8'h6C, 8'h09, 8'h00, 8'h00, 8'h80};
        offer_frame(frame, 1'b0, 0);
        // channel 14 with fhss, no signal field
        frame = {8'h00, 8'h00, 8'h0C, 8'h00, 8'h18, 8'h00, 8'h00, 8'h00,
                 8'hB4, 8'h09, 8'hA0, 8'h00};
        offer_frame(frame, 1'b1, 0);
        // one byte header marked first and last
        offer_byte(8'h00, 1'b1, 1'b1);

        for (int ph = 0; ph < 3; ph++) begin
            case (ph)
                0: begin send_idle_pct = 31; recv_idle_pct = 88; end
                1: begin send_idle_pct = 88; recv_idle_pct = 31; end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                    hold_off_req = 1'b1;
                end
            endcase
            while (bytes_taken < 150 * (ph + 1)) begin
                if ($urandom_range(99) < 8) begin
                    repeat ($urandom_range(1, 6)) begin
                        offer_byte(8'($urandom_range(255)), $urandom_range(3) == 0,
                                   $urandom_range(2) == 0);
                    end
                end else begin
                    make_header(frame);
                    offer_frame(frame, $urandom_range(9) != 0, 4);
                end
            end
        end
        s_valid <= 1'b0;

        while (tracker.pending() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (tracker.errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

FILE: filelist.f
hdl/rtcsp_pkg.sv
hdl/radiotap_channel_signal_parser.sv
bench/radiotap_channel_signal_parser_test.sv
